@@ rtl/cpax_pkg.sv @@
// shared constants and helpers for the colour pair allocator
// no dependencies; used by every module of the block by scoped names
package cpax_pkg;

  localparam int PAIR_SLOTS = 256;
  localparam int IDX_W      = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam int CNT_W      = IDX_W + 1;

  localparam int RGB_W  = 24;
  localparam int KEY_W  = 2 * RGB_W;
  localparam int CODE_W = 8;
  localparam int PIDX_W = 8;
  localparam int CH_W   = 8;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  // reciprocal constants for the two constant divisions in the quantizer
  localparam logic [9:0]  DIV3_MUL  = 10'd683;
  localparam int          DIV3_SH   = 11;
  localparam logic [7:0]  DIV10_MUL = 8'd205;
  localparam int          DIV10_SH  = 11;

  localparam logic [7:0] GRAY_MAX_AVG = 8'd238;
  localparam logic [7:0] GRAY_MIN_AVG = 8'd3;
  localparam logic [4:0] GRAY_TOP     = 5'd23;
  localparam logic [7:0] GRAY_BASE    = 8'd232;
  localparam logic [7:0] CUBE_BASE    = 8'd16;

  // channel value to cube level index
  function automatic logic [2:0] level_step(input logic [CH_W-1:0] v);
    logic [2:0] s;
    begin
      if (v < 8'd48) s = 3'd0;
      else if (v < 8'd115) s = 3'd1;
      else if (v < 8'd155) s = 3'd2;
      else if (v < 8'd195) s = 3'd3;
      else if (v < 8'd235) s = 3'd4;
      else s = 3'd5;
      return s;
    end
  endfunction

  function automatic logic [CH_W-1:0] cube_level(input logic [2:0] idx);
    logic [CH_W-1:0] lv;
    begin
      case (idx)
        3'd0: lv = 8'h00;
        3'd1: lv = 8'h5f;
        3'd2: lv = 8'h87;
        3'd3: lv = 8'haf;
        3'd4: lv = 8'hd7;
        3'd5: lv = 8'hff;
        default: lv = 8'h00;
      endcase
      return lv;
    end
  endfunction

endpackage

@@ rtl/cpax_pair_ram.sv @@
// pair store: single write port, single registered read port
// depends on cpax_pkg for depth and key width
module cpax_pair_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [cpax_pkg::IDX_W-1:0]    waddr,
  input  logic [cpax_pkg::KEY_W-1:0]    wdata,
  input  logic                          re,
  input  logic [cpax_pkg::IDX_W-1:0]    raddr,
  output logic [cpax_pkg::KEY_W-1:0]    rdata
);

  logic [cpax_pkg::KEY_W-1:0] mem [cpax_pkg::PAIR_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/cpax_quant.sv @@
// four-stage rgb to xterm-256 code quantizer (cube vs gray ramp by squared error)
// depends on cpax_pkg for level tables and division constants
module cpax_quant (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cpax_pkg::RGB_W-1:0]    rgb,
  output logic                          done,
  output logic [cpax_pkg::CODE_W-1:0]   code
);

  // stage 1
  logic [7:0]  r1_r, g1_r, b1_r, avg1_r;
  logic [2:0]  ir1_r, ig1_r, ib1_r;
  logic        v1_r;
  logic [9:0]  sum;
  logic [19:0] avg_prod;

  // stage 2
  logic signed [8:0] dcr2_r, dcg2_r, dcb2_r, dgr2_r, dgg2_r, dgb2_r;
  logic [4:0]  gk2_r;
  logic [7:0]  cc2_r;
  logic        v2_r;
  logic [7:0]  avg_off;
  logic [15:0] gk_prod;
  logic [4:0]  gk;
  logic [7:0]  gv;
  logic [7:0]  cc;

  // stage 3
  logic [15:0] scr3_r, scg3_r, scb3_r, sgr3_r, sgg3_r, sgb3_r;
  logic [4:0]  gk3_r;
  logic [7:0]  cc3_r;
  logic        v3_r;
  logic signed [17:0] pcr, pcg, pcb, pgr, pgg, pgb;

  // stage 4
  logic [17:0] cube_err, ramp_err;
  logic [7:0]  code_r;
  logic        done_r;

  assign sum      = 10'(rgb[23:16]) + 10'(rgb[15:8]) + 10'(rgb[7:0]);
  assign avg_prod = 20'(sum) * 20'(cpax_pkg::DIV3_MUL);

  assign avg_off = avg1_r - cpax_pkg::GRAY_MIN_AVG;
  assign gk_prod = 16'(avg_off) * 16'(cpax_pkg::DIV10_MUL);

  always_comb begin
    if (avg1_r > cpax_pkg::GRAY_MAX_AVG) gk = cpax_pkg::GRAY_TOP;
    else if (avg1_r < cpax_pkg::GRAY_MIN_AVG) gk = 5'd0;
    else gk = gk_prod[cpax_pkg::DIV10_SH +: 5];
  end

  assign gv = 8'd8 + 8'(gk) * 8'd10;
  assign cc = cpax_pkg::CUBE_BASE + 8'(ir1_r) * 8'd36 + 8'(ig1_r) * 8'd6 + 8'(ib1_r);

  assign pcr = 18'(dcr2_r) * 18'(dcr2_r);
  assign pcg = 18'(dcg2_r) * 18'(dcg2_r);
  assign pcb = 18'(dcb2_r) * 18'(dcb2_r);
  assign pgr = 18'(dgr2_r) * 18'(dgr2_r);
  assign pgg = 18'(dgg2_r) * 18'(dgg2_r);
  assign pgb = 18'(dgb2_r) * 18'(dgb2_r);

  assign cube_err = 18'(scr3_r) + 18'(scg3_r) + 18'(scb3_r);
  assign ramp_err = 18'(sgr3_r) + 18'(sgg3_r) + 18'(sgb3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    r1_r   <= rgb[23:16];
    g1_r   <= rgb[15:8];
    b1_r   <= rgb[7:0];
    ir1_r  <= cpax_pkg::level_step(rgb[23:16]);
    ig1_r  <= cpax_pkg::level_step(rgb[15:8]);
    ib1_r  <= cpax_pkg::level_step(rgb[7:0]);
    avg1_r <= avg_prod[cpax_pkg::DIV3_SH +: 8];

    dcr2_r <= $signed({1'b0, cpax_pkg::cube_level(ir1_r)}) - $signed({1'b0, r1_r});
    dcg2_r <= $signed({1'b0, cpax_pkg::cube_level(ig1_r)}) - $signed({1'b0, g1_r});
    dcb2_r <= $signed({1'b0, cpax_pkg::cube_level(ib1_r)}) - $signed({1'b0, b1_r});
    dgr2_r <= $signed({1'b0, gv}) - $signed({1'b0, r1_r});
    dgg2_r <= $signed({1'b0, gv}) - $signed({1'b0, g1_r});
    dgb2_r <= $signed({1'b0, gv}) - $signed({1'b0, b1_r});
    gk2_r  <= gk;
    cc2_r  <= cc;

    scr3_r <= 16'(pcr);
    scg3_r <= 16'(pcg);
    scb3_r <= 16'(pcb);
    sgr3_r <= 16'(pgr);
    sgg3_r <= 16'(pgg);
    sgb3_r <= 16'(pgb);
    gk3_r  <= gk2_r;
    cc3_r  <= cc2_r;

    if (v3_r) begin
      code_r <= (cube_err <= ramp_err) ? cc3_r : (cpax_pkg::GRAY_BASE + 8'(gk3_r));
    end
  end

  assign done = done_r;
  assign code = code_r;

endmodule

@@ rtl/colour_pair_allocator_xterm256.sv @@
// colour pair allocator top level: search sequencer, pair store, two quantizers
// depends on cpax_pkg, cpax_pair_ram and cpax_quant
//
// Each input beat carries a foreground/background rgb pair. The block scans the
// stored pairs in insertion order, one read of the pair store per cycle, and
// returns the index of the first exact match. On a miss the pair is appended
// and both colours are quantized to xterm-256 codes (four-stage quantizer), and
// the beat is flagged new; when the store already holds PAIR_SLOTS pairs
// nothing is stored and table_full is flagged with index 0. One item at a time:
// the time an item takes grows with the entry of its match on a hit, and with
// the number of stored pairs on a miss; an insert also waits for both
// quantizers to finish. The next item is taken while a result still waits in
// the output register.
module colour_pair_allocator_xterm256 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cpax_pkg::IN_DATA_W-1:0]     in_tdata,   // fore_rgb [23:0], back_rgb [47:24]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pair_index [7:0], fore_code [15:8], back_code [23:16]
  output logic [cpax_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [cpax_pkg::OUT_USER_W-1:0]    out_tuser   // is_new [0], table_full [1]
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_QUANT = 2'd2;
  localparam logic [1:0] ST_RES   = 2'd3;

  localparam logic [cpax_pkg::CNT_W-1:0] SLOTS = cpax_pkg::CNT_W'(cpax_pkg::PAIR_SLOTS);

  logic [1:0] st_r, st_nxt;
  logic [cpax_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [cpax_pkg::CNT_W-1:0] issue_r, issue_nxt;
  logic [cpax_pkg::CNT_W-1:0] pidx_r, pidx_nxt;
  logic pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [cpax_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [cpax_pkg::PIDX_W-1:0] res_idx_r, res_idx_nxt;
  logic res_new_r, res_new_nxt;
  logic res_full_r, res_full_nxt;
  logic [cpax_pkg::CODE_W-1:0] res_fc_r, res_fc_nxt, res_bc_r, res_bc_nxt;
  logic [cpax_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [cpax_pkg::OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic [cpax_pkg::KEY_W-1:0] rd_data;
  logic rd_en, wr_en, q_start, hit, more;
  logic fq_done, bq_done;
  logic [cpax_pkg::CODE_W-1:0] fq_code, bq_code;

  cpax_pair_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[cpax_pkg::IDX_W-1:0]),
    .wdata (key_r),
    .re    (rd_en),
    .raddr (issue_r[cpax_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  cpax_quant u_fq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (q_start),
    .rgb   (key_r[cpax_pkg::KEY_W-1:cpax_pkg::RGB_W]),
    .done  (fq_done),
    .code  (fq_code)
  );

  cpax_quant u_bq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (q_start),
    .rgb   (key_r[cpax_pkg::RGB_W-1:0]),
    .done  (bq_done),
    .code  (bq_code)
  );

  assign hit  = pend_r && (rd_data == key_r);
  assign more = issue_r < count_r;

  always_comb begin
    st_nxt        = st_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    pidx_nxt      = pidx_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r;
    key_nxt       = key_r;
    res_idx_nxt   = res_idx_r;
    res_new_nxt   = res_new_r;
    res_full_nxt  = res_full_r;
    res_fc_nxt    = res_fc_r;
    res_bc_nxt    = res_bc_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    q_start       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          key_nxt   = {in_tdata[23:0], in_tdata[47:24]};
          issue_nxt = '0;
          st_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        res_fc_nxt = '0;
        res_bc_nxt = '0;
        if (hit) begin
          res_idx_nxt  = cpax_pkg::PIDX_W'(pidx_r);
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          st_nxt       = ST_RES;
        end else if (more) begin
          rd_en     = 1'b1;
          pend_nxt  = 1'b1;
          pidx_nxt  = issue_r;
          issue_nxt = issue_r + 1'b1;
        end else if (count_r >= SLOTS) begin
          res_idx_nxt  = '0;
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b1;
          st_nxt       = ST_RES;
        end else begin
          wr_en        = 1'b1;
          q_start      = 1'b1;
          res_idx_nxt  = cpax_pkg::PIDX_W'(count_r);
          res_new_nxt  = 1'b1;
          res_full_nxt = 1'b0;
          count_nxt    = count_r + 1'b1;
          st_nxt       = ST_QUANT;
        end
      end
      ST_QUANT: begin
        if (fq_done && bq_done) begin
          res_fc_nxt = fq_code;
          res_bc_nxt = bq_code;
          st_nxt     = ST_RES;
        end
      end
      ST_RES: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_bc_r, res_fc_r, res_idx_r};
          out_user_nxt  = {res_full_r, res_new_r};
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    key_r      <= key_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    res_fc_r   <= res_fc_nxt;
    res_bc_r   <= res_bc_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
